// File: hw/rtl/dgc_pkg.sv
// Shared constants for the detection gating cache: sizing defaults, field widths,
// command and status codes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package dgc_pkg;

  // Default sizing handed to the top level
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned CoordBitsDef  = 16;

  // Fixed field widths
  localparam int unsigned THR_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HITS_W   = 16;
  localparam int unsigned FIELD7_W = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIST_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRE   = 1'd1;

  // Reset values: 0.25 m threshold, 5 s expiry
  localparam logic [THR_W-1:0]  DIST_THR_RST = 16'd64;
  localparam logic [TIME_W-1:0] EXPIRE_RST   = 32'd5000;

  // Command codes
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_SWEEP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MATCHED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SWEPT    = 2'd3;

endpackage

// File: hw/rtl/dgc_if.sv
// Valid/ready channel interfaces for the detection gating cache.
// Depends on dgc_pkg for field widths.
`timescale 1ns / 1ps

interface dgc_in_if #(
  parameter int unsigned COORD_BITS = dgc_pkg::CoordBitsDef
);
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic signed [COORD_BITS-1:0]    pos_x;
  logic signed [COORD_BITS-1:0]    pos_y;
  logic [dgc_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, cmd, pos_x, pos_y, now_ms, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, now_ms, output ready);
endinterface

interface dgc_out_if;
  logic                            valid;
  logic                            ready;
  logic [dgc_pkg::STATUS_W-1:0]    status;
  logic [dgc_pkg::FIELD7_W-1:0]    affected;
  logic [dgc_pkg::FIELD7_W-1:0]    occupied;

  modport source (output valid, status, affected, occupied, input ready);
  modport sink   (input valid, status, affected, occupied, output ready);
endinterface

// File: hw/rtl/detection_gating_cache_core.sv
// Detection gating cache top level: sequencer, compare pipeline and table RAM.
// Depends on dgc_pkg, dgc_in_if, dgc_out_if and dgc_ram.
`timescale 1ns / 1ps

// Keeps a table of TABLE_DEPTH remembered 2D points (signed Q8.8 metres) with a
// saturating hit count and a last-seen time. A point item updates every entry
// closer than the threshold, or inserts into the lowest free slot, or is
// dropped when the table is full; a sweep item frees entries older than the
// expiry. The table lives in one RAM with one read and one write port; the
// sequencer reads one entry per cycle through a three-stage compare pipeline
// (read, difference and bound check, square and compare) and writes updates
// back behind it; a finish step then loads the result. One result register
// decouples the output, so the next item is taken while a result waits. After
// reset the block runs a clearing pass over every entry before it takes an
// item; configuration writes are taken at any time.
module detection_gating_cache_core #(
  parameter int unsigned TABLE_DEPTH = dgc_pkg::TableDepthDef,
  parameter int unsigned COORD_BITS  = dgc_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dgc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dgc_pkg::CFG_W-1:0]         cfg_data_i,
  dgc_in_if.sink                            in_ch,
  dgc_out_if.source                         out_ch
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned MW  = (DW > dgc_pkg::THR_W) ? DW : dgc_pkg::THR_W;
  localparam int unsigned SQW = 2 * dgc_pkg::THR_W;
  localparam int unsigned TW  = dgc_pkg::TIME_W;
  localparam int unsigned HW  = dgc_pkg::HITS_W;
  localparam int unsigned EW  = 1 + 2 * COORD_BITS + HW + TW;

  // Entry word layout: valid, x, y, hits, seen
  localparam int unsigned SEEN_LO = 0;
  localparam int unsigned HITS_LO = TW;
  localparam int unsigned Y_LO    = TW + HW;
  localparam int unsigned X_LO    = Y_LO + COORD_BITS;
  localparam int unsigned VAL_B   = EW - 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  logic [2:0] state_q, state_d;

  // Configuration registers and squared threshold
  logic [dgc_pkg::THR_W-1:0] thr_q;
  logic [TW-1:0]             exp_q;
  logic [SQW-1:0]            thr_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= dgc_pkg::DIST_THR_RST;
      exp_q <= dgc_pkg::EXPIRE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dgc_pkg::REG_DIST_THR: thr_q <= cfg_data_i[dgc_pkg::THR_W-1:0];
        dgc_pkg::REG_EXPIRE:   exp_q <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
  end

  // Item registers
  logic                         cmd_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [TW-1:0]                now_q;

  logic in_xfer;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= in_ch.cmd;
      px_q  <= in_ch.pos_x;
      py_q  <= in_ch.pos_y;
      now_q <= in_ch.now_ms;
    end
  end

  // Sequencer counters and flags
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] aff_q, aff_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] free_q, free_d;
  logic          found_q, found_d;
  logic          rv_q;
  logic [AW-1:0] ra_q;

  logic          cnt_live;
  logic          rd_en;
  assign cnt_live = (cnt_q < CW'(TABLE_DEPTH));
  assign rd_en    = (state_q == ST_SCAN) && cnt_live;

  // Table RAM
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  dgc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Stage 1: differences, bound check and age check on the read entry
  logic                         r_val;
  logic signed [COORD_BITS-1:0] r_x, r_y;
  logic signed [DW-1:0]         dfx, dfy;
  logic [DW-1:0]                adx, ady;
  logic [TW-1:0]                age;
  logic                         pre_near, expired;

  always_comb begin
    r_val = rdata[VAL_B];
    r_x   = rdata[X_LO +: COORD_BITS];
    r_y   = rdata[Y_LO +: COORD_BITS];
    dfx   = $signed({r_x[COORD_BITS-1], r_x}) - $signed({px_q[COORD_BITS-1], px_q});
    dfy   = $signed({r_y[COORD_BITS-1], r_y}) - $signed({py_q[COORD_BITS-1], py_q});
    adx   = dfx[DW-1] ? DW'(-dfx) : DW'(dfx);
    ady   = dfy[DW-1] ? DW'(-dfy) : DW'(dfy);
    pre_near = r_val && (MW'(adx) < MW'(thr_q)) && (MW'(ady) < MW'(thr_q));
    age      = now_q - rdata[SEEN_LO +: TW];
    expired  = r_val && (age > exp_q);
  end

  logic                    s2v_q;
  logic [AW-1:0]           s2a_q;
  logic [EW-1:0]           s2e_q;
  logic                    s2pre_q, s2exp_q;
  logic [dgc_pkg::THR_W-1:0] s2dx_q, s2dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      s2v_q <= 1'b0;
    end else begin
      rv_q  <= rd_en;
      s2v_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q    <= cnt_q[AW-1:0];
    s2a_q   <= ra_q;
    s2e_q   <= rdata;
    s2pre_q <= pre_near;
    s2exp_q <= expired;
    s2dx_q  <= dgc_pkg::THR_W'(adx);
    s2dy_q  <= dgc_pkg::THR_W'(ady);
  end

  // Stage 2: squared distance against squared threshold
  logic [SQW-1:0] sqx, sqy;
  logic [SQW:0]   dsum;
  logic           s2_match;
  logic [HW-1:0]  s2_hits, hits_inc;

  always_comb begin
    sqx      = s2dx_q * s2dx_q;
    sqy      = s2dy_q * s2dy_q;
    dsum     = {1'b0, sqx} + {1'b0, sqy};
    s2_match = s2pre_q && (dsum < {1'b0, thr_sq_q});
    s2_hits  = s2e_q[HITS_LO +: HW];
    hits_inc = (s2_hits == dgc_pkg::HITS_MAX) ? s2_hits : s2_hits + 1'b1;
  end

  // Output register
  logic                         out_v_q;
  logic [dgc_pkg::STATUS_W-1:0] out_st_q;
  logic [dgc_pkg::FIELD7_W-1:0] out_aff_q, out_occ_q;
  logic                         out_free;

  assign out_free        = !out_v_q || out_ch.ready;
  assign out_ch.valid    = out_v_q;
  assign out_ch.status   = out_st_q;
  assign out_ch.affected = out_aff_q;
  assign out_ch.occupied = out_occ_q;

  logic                         ld_out;
  logic [dgc_pkg::STATUS_W-1:0] st_next;

  // Sequencer: clear, scan, write back and finish
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    aff_d   = aff_q;
    occ_d   = occ_q;
    free_d  = free_q;
    found_d = found_q;
    we      = 1'b0;
    waddr   = s2a_q;
    wdata   = s2e_q;
    ld_out  = 1'b0;
    st_next = dgc_pkg::ST_SWEPT;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          aff_d   = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (cnt_live) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (s2v_q) begin
          if (cmd_q == dgc_pkg::CMD_SWEEP) begin
            if (s2exp_q) begin
              we           = 1'b1;
              wdata[VAL_B] = 1'b0;
              aff_d        = aff_q + 1'b1;
              occ_d        = occ_q - 1'b1;
            end
          end else begin
            if (s2_match) begin
              we                     = 1'b1;
              wdata[HITS_LO +: HW]   = hits_inc;
              wdata[SEEN_LO +: TW]   = now_q;
              aff_d                  = aff_q + 1'b1;
            end
            if (!s2e_q[VAL_B] && !found_q) begin
              free_d  = s2a_q;
              found_d = 1'b1;
            end
          end
        end
        if (!cnt_live && !rv_q && !s2v_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ld_out  = 1'b1;
          state_d = ST_IDLE;
          if (cmd_q == dgc_pkg::CMD_SWEEP) begin
            st_next = dgc_pkg::ST_SWEPT;
          end else if (aff_q != '0) begin
            st_next = dgc_pkg::ST_MATCHED;
          end else if (found_q) begin
            st_next = dgc_pkg::ST_INSERTED;
            we      = 1'b1;
            waddr   = free_q;
            wdata   = {1'b1, px_q, py_q, HW'(1), now_q};
            occ_d   = occ_q + 1'b1;
          end else begin
            st_next = dgc_pkg::ST_DROPPED;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      aff_q   <= '0;
      occ_q   <= '0;
      free_q  <= '0;
      found_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      aff_q   <= aff_d;
      occ_q   <= occ_d;
      free_q  <= free_d;
      found_q <= found_d;
      if (ld_out) begin
        out_v_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next load
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_st_q  <= st_next;
      out_aff_q <= dgc_pkg::FIELD7_W'(aff_q);
      out_occ_q <= dgc_pkg::FIELD7_W'(occ_d);
    end
  end

endmodule

// File: hw/rtl/dgc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dgc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
